[rtl/script_token_lexer_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the script token lexer
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ---------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_LEXER_ASSERT_SVH
`define SCRIPT_TOKEN_LEXER_ASSERT_SVH

// implication checked every edge outside reset
`define STL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("script_token_lexer: implication check failed");

// next-cycle implication checked outside reset
`define STL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("script_token_lexer: next-cycle check failed");

`endif

[rtl/stl_pkg.sv]
// ---------------------------------------------------------------------------
// stl_pkg
// Types, codes and helper functions shared by the script token lexer.
// ---------------------------------------------------------------------------
package stl_pkg;

  localparam int OFFSET_BITS_DEF = 24;
  localparam int ROW_BITS_DEF    = 16;
  localparam int COL_BITS_DEF    = 16;

  localparam int KIND_W = 6;
  localparam int ERR_W  = 2;
  localparam int OFF_W  = 24;
  localparam int POS_W  = 16;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_IDENT   = 3'd1,
    M_NUMBER  = 3'd2,
    M_STRING  = 3'd3,
    M_ESC     = 3'd4,
    M_SYMBOL  = 3'd5,
    M_COMMENT = 3'd6
  } lex_mode_t;

  localparam logic [KIND_W-1:0] K_END     = 6'd0;
  localparam logic [KIND_W-1:0] K_ERROR   = 6'd1;
  localparam logic [KIND_W-1:0] K_IDENT   = 6'd2;
  localparam logic [KIND_W-1:0] K_KEYWORD = 6'd3;
  localparam logic [KIND_W-1:0] K_CATCH   = 6'd4;
  localparam logic [KIND_W-1:0] K_NUMBER  = 6'd5;
  localparam logic [KIND_W-1:0] K_STRING  = 6'd6;
  localparam logic [KIND_W-1:0] K_LPAREN  = 6'd7;
  localparam logic [KIND_W-1:0] K_RPAREN  = 6'd8;
  localparam logic [KIND_W-1:0] K_LBRACK  = 6'd9;
  localparam logic [KIND_W-1:0] K_RBRACK  = 6'd10;
  localparam logic [KIND_W-1:0] K_LBRACE  = 6'd11;
  localparam logic [KIND_W-1:0] K_RBRACE  = 6'd12;
  localparam logic [KIND_W-1:0] K_COMMA   = 6'd13;
  localparam logic [KIND_W-1:0] K_PLUS    = 6'd14;
  localparam logic [KIND_W-1:0] K_MINUS   = 6'd15;
  localparam logic [KIND_W-1:0] K_STAR    = 6'd16;
  localparam logic [KIND_W-1:0] K_SLASH   = 6'd17;
  localparam logic [KIND_W-1:0] K_LT      = 6'd18;
  localparam logic [KIND_W-1:0] K_GT      = 6'd19;
  localparam logic [KIND_W-1:0] K_EQ      = 6'd20;
  localparam logic [KIND_W-1:0] K_BANG    = 6'd21;
  localparam logic [KIND_W-1:0] K_COLON   = 6'd22;
  localparam logic [KIND_W-1:0] K_PLUSEQ  = 6'd23;
  localparam logic [KIND_W-1:0] K_MINUSEQ = 6'd24;
  localparam logic [KIND_W-1:0] K_STAREQ  = 6'd25;
  localparam logic [KIND_W-1:0] K_SLASHEQ = 6'd26;
  localparam logic [KIND_W-1:0] K_LE      = 6'd27;
  localparam logic [KIND_W-1:0] K_GE      = 6'd28;
  localparam logic [KIND_W-1:0] K_EQEQ    = 6'd29;
  localparam logic [KIND_W-1:0] K_NE      = 6'd30;
  localparam logic [KIND_W-1:0] K_ANDAND  = 6'd31;
  localparam logic [KIND_W-1:0] K_OROR    = 6'd32;
  localparam logic [KIND_W-1:0] K_COLCOL  = 6'd33;
  localparam logic [KIND_W-1:0] K_ARROW   = 6'd34;

  localparam logic [ERR_W-1:0] E_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] E_SYMBOL = 2'd1;
  localparam logic [ERR_W-1:0] E_DOUBLE = 2'd2;

  localparam int NUM_KW = 12;
  typedef logic [47:0] kw_word_t;
  localparam kw_word_t KW_TEXT [NUM_KW] = '{
    48'h000000006669,   // if
    48'h00006e656874,   // then
    48'h000065736c65,   // else
    48'h0068637461_6d,  // match
    48'h000068746977,   // with
    48'h000000646e65,   // end
    48'h000065757274,   // true
    48'h0065736c6166,   // false
    48'h000000666e69,   // inf
    48'h656d616e6572,   // rename
    48'h656c75646f6d,   // module
    48'h646f6d646e65    // endmod
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd2, 3'd4, 3'd4, 3'd5, 3'd4, 3'd3, 3'd4, 3'd5, 3'd3, 3'd6, 3'd6, 3'd6
  };

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [OFF_W-1:0]  start;
    logic [OFF_W-1:0]  len;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lead(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == 8'h5f);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_lead(c) || is_digit(c) || (c == 8'h2e);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h0a) || (c == 8'h0d) || (c == 8'h09);
  endfunction

endpackage

[rtl/script_token_lexer.sv]
// ---------------------------------------------------------------------------
// script_token_lexer
// Streaming lexer: one source byte in, zero to two tokens out per byte.
// ---------------------------------------------------------------------------
// One byte is taken per cycle while the output queue has room; a byte that
// yields two tokens (a word, number or glyph closed by a byte that itself
// emits) holds in_tready low while the second drains.
// NUL ends a text with an end token and restarts counting at row 1.
module script_token_lexer #(
  parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEF,
  parameter int ROW_BITS    = stl_pkg::ROW_BITS_DEF,
  parameter int COL_BITS    = stl_pkg::COL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,   // error_code, start_offset, value_length, row, column
  output logic [5:0]  out_tuser,   // token_kind
  output logic        out_tlast    // last
);
  import stl_pkg::*;

  logic   step, t0v, t1v;
  token_t t0, t1, q;

  assign step = in_tvalid && in_tready;

  stl_core #(
    .OFFSET_BITS(OFFSET_BITS), .ROW_BITS(ROW_BITS), .COL_BITS(COL_BITS)
  ) u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .ch(in_tdata),
    .tok0_vld(t0v), .tok0(t0), .tok1_vld(t1v), .tok1(t1)
  );

  stl_outq u_outq (
    .clk(clk), .rst_n(rst_n),
    .push0(step && t0v), .d0(t0), .push1(step && t1v), .d1(t1),
    .room(in_tready), .out_vld(out_tvalid), .out_rdy(out_tready),
    .q(q), .q_last(out_tlast)
  );

  assign out_tuser = q.kind;
  assign out_tdata = {14'b0, q.col, q.row, q.len, q.start, q.err};

endmodule

[rtl/stl_core.sv]
// ---------------------------------------------------------------------------
// stl_core
// Lexer state and one-byte decode: yields up to two tokens per source byte.
// ---------------------------------------------------------------------------
module stl_core #(
  parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEF,
  parameter int ROW_BITS    = stl_pkg::ROW_BITS_DEF,
  parameter int COL_BITS    = stl_pkg::COL_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      ch,
  output logic            tok0_vld,
  output stl_pkg::token_t tok0,
  output logic            tok1_vld,
  output stl_pkg::token_t tok1
);
  import stl_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [ROW_BITS-1:0]    ROW_MAX = '1;
  localparam logic [COL_BITS-1:0]    COL_MAX = '1;

  lex_mode_t               mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0]  off_r, off_nxt, start_r, start_nxt, len_r, len_nxt;
  logic [ROW_BITS-1:0]     row_r, row_nxt, trow_r, trow_nxt;
  logic [COL_BITS-1:0]     col_r, col_nxt, tcol_r, tcol_nxt;
  logic [47:0]             pfx_r, pfx_nxt;

  logic [ROW_BITS-1:0]     r;
  logic [COL_BITS-1:0]     c;
  logic [OFFSET_BITS-1:0]  len_inc;
  logic                    rescan, ended;
  logic [7:0]              g;
  logic [KIND_W-1:0]       k, wkind;
  logic                    kw_hit;

  function automatic logic [OFF_W-1:0] off_o(input logic [OFFSET_BITS-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[OFF_W-1:0];
  endfunction
  function automatic logic [POS_W-1:0] row_o(input logic [ROW_BITS-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[POS_W-1:0];
  endfunction
  function automatic logic [POS_W-1:0] col_o(input logic [COL_BITS-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[POS_W-1:0];
  endfunction

  function automatic token_t mk(input logic [KIND_W-1:0] kd, input logic [ERR_W-1:0] e,
                                input logic [OFF_W-1:0] s, input logic [OFF_W-1:0] l,
                                input logic [POS_W-1:0] rw, input logic [POS_W-1:0] cl);
    token_t t;
    t.kind = kd; t.err = e; t.start = s; t.len = l; t.row = rw; t.col = cl;
    return t;
  endfunction

  assign len_inc = (len_r == OFF_MAX) ? len_r : len_r + 1'b1;

  always_comb begin
    kw_hit = 1'b0;
    for (int i = 0; i < NUM_KW; i++) begin
      if ((len_r == OFFSET_BITS'(KW_LEN[i])) && (pfx_r == KW_TEXT[i])) kw_hit = 1'b1;
    end
    if ((len_r == OFFSET_BITS'(1)) && (pfx_r[7:0] == 8'h5f)) wkind = K_CATCH;
    else if (kw_hit) wkind = K_KEYWORD;
    else wkind = K_IDENT;
  end

  always_comb begin
    logic [7:0] tmp;
    tmp = 8'h0;
    mode_nxt  = mode_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    trow_nxt  = trow_r;
    tcol_nxt  = tcol_r;
    pfx_nxt   = pfx_r;
    tok0_vld  = 1'b0;
    tok1_vld  = 1'b0;
    tok0      = '0;
    tok1      = '0;
    rescan    = 1'b0;
    ended     = 1'b0;
    g         = pfx_r[7:0];
    k         = K_END;
    if (ch == 8'h0a) begin
      r = (row_r == ROW_MAX) ? row_r : row_r + 1'b1;
      c = '0;
    end else begin
      r = row_r;
      c = (col_r == COL_MAX) ? col_r : col_r + 1'b1;
    end

    case (mode_r)
      M_IDENT: begin
        if (is_word(ch)) begin
          case (len_r)
            OFFSET_BITS'(0): pfx_nxt[7:0]   = ch;
            OFFSET_BITS'(1): pfx_nxt[15:8]  = pfx_r[15:8] | ch;
            OFFSET_BITS'(2): pfx_nxt[23:16] = pfx_r[23:16] | ch;
            OFFSET_BITS'(3): pfx_nxt[31:24] = pfx_r[31:24] | ch;
            OFFSET_BITS'(4): pfx_nxt[39:32] = pfx_r[39:32] | ch;
            OFFSET_BITS'(5): pfx_nxt[47:40] = pfx_r[47:40] | ch;
            default: pfx_nxt = pfx_r;
          endcase
          len_nxt = len_inc;
        end else begin
          tok0_vld = 1'b1;
          tok0 = mk(wkind, E_NONE, off_o(start_r), off_o(len_r), row_o(trow_r), col_o(tcol_r));
          rescan = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(ch)) len_nxt = len_inc;
        else begin
          tok0_vld = 1'b1;
          tok0 = mk(K_NUMBER, E_NONE, off_o(start_r), off_o(len_r), row_o(trow_r),
                    col_o(tcol_r));
          rescan = 1'b1;
        end
      end
      M_STRING: begin
        if (ch == 8'h00) rescan = 1'b1;
        else if (ch == 8'h22) begin
          tok0_vld = 1'b1;
          tok0 = mk(K_STRING, E_NONE,
                    off_o((start_r == OFF_MAX) ? start_r : start_r + 1'b1),
                    off_o(len_r), row_o(trow_r), col_o(tcol_r));
          mode_nxt = M_IDLE;
        end else begin
          len_nxt = len_inc;
          if (ch == 8'h5c) mode_nxt = M_ESC;
        end
      end
      M_ESC: begin
        if (ch == 8'h00) rescan = 1'b1;
        else begin
          len_nxt = len_inc;
          mode_nxt = M_STRING;
        end
      end
      M_SYMBOL: begin
        mode_nxt = M_IDLE;
        tok0_vld = 1'b1;
        if (ch == 8'h3d) begin
          case (g)
            8'h2b: k = K_PLUSEQ;
            8'h2d: k = K_MINUSEQ;
            8'h2a: k = K_STAREQ;
            8'h2f: k = K_SLASHEQ;
            8'h3c: k = K_LE;
            8'h3e: k = K_GE;
            8'h3d: k = K_EQEQ;
            8'h21: k = K_NE;
            default: k = K_END;
          endcase
        end else if (ch == 8'h26 && g == 8'h26) k = K_ANDAND;
        else if (ch == 8'h7c && g == 8'h7c) k = K_OROR;
        else if (ch == 8'h3a && g == 8'h3a) k = K_COLCOL;
        else if (ch == 8'h3e && g == 8'h3d) k = K_ARROW;
        if (ch == 8'h3d || k != K_END) begin
          if (k != K_END)
            tok0 = mk(k, E_NONE, off_o(start_r), OFF_W'(2), row_o(trow_r), col_o(tcol_r));
          else
            tok0 = mk(K_ERROR, E_DOUBLE, off_o(start_r), '0, row_o(trow_r), col_o(tcol_r));
        end else begin
          rescan = 1'b1;
          case (g)
            8'h2b: k = K_PLUS;
            8'h2d: k = K_MINUS;
            8'h2a: k = K_STAR;
            8'h2f: k = K_SLASH;
            8'h3c: k = K_LT;
            8'h3e: k = K_GT;
            8'h3d: k = K_EQ;
            8'h21: k = K_BANG;
            8'h3a: k = K_COLON;
            default: k = K_END;
          endcase
          if (k != K_END)
            tok0 = mk(k, E_NONE, off_o(start_r), OFF_W'(1), row_o(trow_r), col_o(tcol_r));
          else
            tok0 = mk(K_ERROR, E_DOUBLE, off_o(start_r), '0, row_o(trow_r), col_o(tcol_r));
        end
      end
      M_COMMENT: begin
        if (ch == 8'h00) rescan = 1'b1;
        else if (ch == 8'h0a) mode_nxt = M_IDLE;
      end
      default: rescan = 1'b1;
    endcase

    if (rescan) begin
      token_t t;
      logic   tv;
      tv = 1'b0;
      t  = mk(K_END, E_NONE, off_o(off_r), '0, row_o(r), col_o(c));
      mode_nxt = M_IDLE;
      if (ch == 8'h00) begin
        tv = 1'b1;
        ended = 1'b1;
      end else if (is_blank(ch)) begin
        tv = 1'b0;
      end else if (is_lead(ch) || is_digit(ch)) begin
        mode_nxt  = is_lead(ch) ? M_IDENT : M_NUMBER;
        start_nxt = off_r; len_nxt = OFFSET_BITS'(1);
        trow_nxt = r; tcol_nxt = c; pfx_nxt = 48'(ch);
      end else begin
        tmp = ch;
        case (tmp)
          8'h28: begin tv = 1'b1; t.kind = K_LPAREN; end
          8'h29: begin tv = 1'b1; t.kind = K_RPAREN; end
          8'h5b: begin tv = 1'b1; t.kind = K_LBRACK; end
          8'h5d: begin tv = 1'b1; t.kind = K_RBRACK; end
          8'h7b: begin tv = 1'b1; t.kind = K_LBRACE; end
          8'h7d: begin tv = 1'b1; t.kind = K_RBRACE; end
          8'h2c: begin tv = 1'b1; t.kind = K_COMMA; end
          8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3c, 8'h3e, 8'h3d, 8'h21, 8'h26, 8'h7c,
          8'h3a: begin
            mode_nxt  = M_SYMBOL;
            start_nxt = off_r; len_nxt = OFFSET_BITS'(1);
            trow_nxt = r; tcol_nxt = c; pfx_nxt = 48'(ch);
          end
          8'h22: begin
            mode_nxt  = M_STRING;
            start_nxt = off_r; len_nxt = '0;
            trow_nxt = r; tcol_nxt = c; pfx_nxt = '0;
          end
          8'h23: mode_nxt = M_COMMENT;
          default: begin tv = 1'b1; t.kind = K_ERROR; t.err = E_SYMBOL; end
        endcase
        if (tv && t.kind != K_ERROR) t.len = OFF_W'(1);
      end
      if (tv) begin
        if (tok0_vld) begin
          tok1_vld = 1'b1;
          tok1 = t;
        end else begin
          tok0_vld = 1'b1;
          tok0 = t;
        end
      end
    end
  end

  assign off_nxt = (off_r == OFF_MAX) ? off_r : off_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; off_r <= '0; start_r <= '0; len_r <= '0;
      row_r <= ROW_BITS'(1); col_r <= '0; trow_r <= ROW_BITS'(1); tcol_r <= '0;
      pfx_r <= '0;
    end else if (step) begin
      if (ended) begin
        mode_r <= M_IDLE; off_r <= '0; start_r <= '0; len_r <= '0;
        row_r <= ROW_BITS'(1); col_r <= '0; trow_r <= ROW_BITS'(1); tcol_r <= '0;
        pfx_r <= '0;
      end else begin
        mode_r <= mode_nxt; off_r <= off_nxt; start_r <= start_nxt; len_r <= len_nxt;
        row_r <= r; col_r <= c; trow_r <= trow_nxt; tcol_r <= tcol_nxt;
        pfx_r <= pfx_nxt;
      end
    end
  end

endmodule

[rtl/stl_outq.sv]
// ---------------------------------------------------------------------------
// stl_outq
// Two-entry result queue: holds both tokens of one byte and drives the beat.
// ---------------------------------------------------------------------------
module stl_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push0,
  input  stl_pkg::token_t d0,
  input  logic            push1,
  input  stl_pkg::token_t d1,
  output logic            room,
  output logic            out_vld,
  input  logic            out_rdy,
  output stl_pkg::token_t q,
  output logic            q_last
);
  import stl_pkg::*;
  `include "script_token_lexer_assert.svh"

  token_t     ent_r [2];
  logic [1:0] lst_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] npush;

  assign pop     = out_vld && out_rdy;
  assign out_vld = cnt_r != 2'd0;
  assign q       = ent_r[0];
  assign q_last  = lst_r[0];
  assign room    = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign npush   = {1'b0, push0} + {1'b0, push1};
  assign cnt_nxt = cnt_r - {1'b0, pop} + npush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r[0] <= ent_r[1];
      lst_r[0] <= lst_r[1];
    end
    if (push0) begin
      if (cnt_r == 2'd0 || pop) begin
        ent_r[0] <= d0; lst_r[0] <= !push1;
        ent_r[1] <= d1; lst_r[1] <= 1'b1;
      end
    end
  end

  `STL_ASSERT_IMP(a_no_overflow, push0, room)
  `STL_ASSERT_IMP(a_push_order, push1, push0)
  `STL_ASSERT_NXT(a_pair_held, (cnt_r == 2'd2) && !out_rdy, cnt_r == 2'd2)
  `STL_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r != 2'd3)

endmodule

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: script token lexer testbench
// Streams source bytes into the lexer under random idling and a long output
// stall, predicts every token from a model of the lexer state and checks
// each output beat's kind, data and last flag in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import stl_pkg::*;

  localparam int WDOG_LIMIT = 4000;

  typedef struct {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [23:0] start;
    logic [23:0] len;
    logic [15:0] row;
    logic [15:0] col;
    logic        last;
  } tok_t;

  typedef struct {
    logic [7:0] ch;
    logic       has_tok;
    logic [5:0] kind;
    logic [1:0] err;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [5:0]  out_tuser;
  logic        out_tlast;

  tok_t tok_q[$];
  int   n_err = 0;
  int   n_sent = 0;
  bit   src_done = 1'b0;
  bit   hold_on = 1'b0;

  lex_mode_t   p_mode;
  logic [23:0] p_off, p_start, p_len;
  logic [15:0] p_row, p_col, p_trow, p_tcol;
  logic [47:0] p_pref;
  tok_t        p_new[$];
  bit          p_end;

  script_token_lexer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [23:0] inc24(logic [23:0] v);
    return (v == 24'hFFFFFF) ? v : v + 24'd1;
  endfunction

  function automatic logic [15:0] inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit lead(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == " " || c == 8'h0a || c == 8'h0d || c == 8'h09;
  endfunction

  task automatic add_tok(logic [5:0] k, logic [1:0] e, logic [23:0] s,
                         logic [23:0] l, logic [15:0] r, logic [15:0] c);
    tok_t t;
    t.kind = k; t.err = e; t.start = s; t.len = l; t.row = r; t.col = c;
    t.last = 1'b0;
    p_new.push_back(t);
  endtask

  function automatic logic [5:0] word_kind();
    string kws[12] = '{"if", "then", "else", "match", "with", "end", "true",
                       "false", "inf", "rename", "module", "endmod"};
    bit ok;
    if (p_len == 1 && p_pref[7:0] == "_") return K_CATCH;
    foreach (kws[i]) begin
      if (p_len == kws[i].len()) begin
        ok = 1'b1;
        for (int j = 0; j < kws[i].len(); j++)
          if (p_pref[8*j +: 8] != kws[i][j]) ok = 1'b0;
        if (ok) return K_KEYWORD;
      end
    end
    return K_IDENT;
  endfunction

  task automatic lex_reset();
    p_mode = M_IDLE; p_off = 0; p_start = 0; p_len = 0;
    p_row = 1; p_col = 0; p_trow = 1; p_tcol = 0; p_pref = 0;
  endtask

  task automatic open_tok(lex_mode_t m, logic [23:0] o, logic [15:0] r,
                          logic [15:0] c, logic [23:0] l, logic [7:0] ch);
    p_mode = m; p_start = o; p_len = l; p_trow = r; p_tcol = c; p_pref = {40'd0, ch};
  endtask

  task automatic scan_idle(logic [7:0] ch, logic [23:0] o, logic [15:0] r,
                           logic [15:0] c);
    p_mode = M_IDLE;
    if (ch == 0) begin
      add_tok(K_END, E_NONE, o, 0, r, c);
      p_end = 1'b1;
    end else if (blank(ch)) begin
    end else if (lead(ch)) open_tok(M_IDENT, o, r, c, 1, ch);
    else if (dig(ch)) open_tok(M_NUMBER, o, r, c, 1, ch);
    else begin
      case (ch)
        "(": add_tok(K_LPAREN, E_NONE, o, 1, r, c);
        ")": add_tok(K_RPAREN, E_NONE, o, 1, r, c);
        "[": add_tok(K_LBRACK, E_NONE, o, 1, r, c);
        "]": add_tok(K_RBRACK, E_NONE, o, 1, r, c);
        "{": add_tok(K_LBRACE, E_NONE, o, 1, r, c);
        "}": add_tok(K_RBRACE, E_NONE, o, 1, r, c);
        ",": add_tok(K_COMMA, E_NONE, o, 1, r, c);
        "+", "-", "*", "/", "<", ">", "=", "!", "&", "|", ":":
          open_tok(M_SYMBOL, o, r, c, 1, ch);
        8'h22: open_tok(M_STRING, o, r, c, 0, 0);
        "#": p_mode = M_COMMENT;
        default: add_tok(K_ERROR, E_SYMBOL, o, 0, r, c);
      endcase
    end
  endtask

  function automatic logic [5:0] single_kind(logic [7:0] g);
    case (g)
      "+": return K_PLUS;   "-": return K_MINUS; "*": return K_STAR;
      "/": return K_SLASH;  "<": return K_LT;    ">": return K_GT;
      "=": return K_EQ;     "!": return K_BANG;  ":": return K_COLON;
      default: return K_END;
    endcase
  endfunction

  function automatic logic [5:0] eq_kind(logic [7:0] g);
    case (g)
      "+": return K_PLUSEQ; "-": return K_MINUSEQ; "*": return K_STAREQ;
      "/": return K_SLASHEQ; "<": return K_LE; ">": return K_GE;
      "=": return K_EQEQ; "!": return K_NE;
      default: return K_END;
    endcase
  endfunction

  task automatic lex_byte(logic [7:0] ch);
    logic [23:0] o;
    logic [15:0] r, c;
    logic [7:0]  g;
    logic [5:0]  k;
    bit          rescan;
    o = p_off; r = p_row; c = p_col; rescan = 1'b0; p_end = 1'b0;
    p_new.delete();
    if (ch == 8'h0a) begin
      r = inc16(r); c = 0;
    end else c = inc16(c);
    case (p_mode)
      M_IDENT: begin
        if (lead(ch) || dig(ch) || ch == ".") begin
          if (p_len < 6) p_pref[8*p_len[2:0] +: 8] = ch;
          p_len = inc24(p_len);
        end else begin
          add_tok(word_kind(), E_NONE, p_start, p_len, p_trow, p_tcol);
          rescan = 1'b1;
        end
      end
      M_NUMBER: begin
        if (dig(ch)) p_len = inc24(p_len);
        else begin
          add_tok(K_NUMBER, E_NONE, p_start, p_len, p_trow, p_tcol);
          rescan = 1'b1;
        end
      end
      M_STRING: begin
        if (ch == 0) rescan = 1'b1;
        else if (ch == 8'h22) begin
          add_tok(K_STRING, E_NONE, inc24(p_start), p_len, p_trow, p_tcol);
          p_mode = M_IDLE;
        end else begin
          p_len = inc24(p_len);
          if (ch == "\\") p_mode = M_ESC;
        end
      end
      M_ESC: begin
        if (ch == 0) rescan = 1'b1;
        else begin
          p_len = inc24(p_len); p_mode = M_STRING;
        end
      end
      M_SYMBOL: begin
        g = p_pref[7:0];
        p_mode = M_IDLE;
        k = K_END;
        if (ch == "=") begin
          k = eq_kind(g);
          if (k != K_END) add_tok(k, E_NONE, p_start, 2, p_trow, p_tcol);
          else add_tok(K_ERROR, E_DOUBLE, p_start, 0, p_trow, p_tcol);
        end else begin
          if (ch == "&" && g == "&") k = K_ANDAND;
          else if (ch == "|" && g == "|") k = K_OROR;
          else if (ch == ":" && g == ":") k = K_COLCOL;
          else if (ch == ">" && g == "=") k = K_ARROW;
          if (k != K_END) add_tok(k, E_NONE, p_start, 2, p_trow, p_tcol);
          else begin
            k = single_kind(g);
            if (k != K_END) add_tok(k, E_NONE, p_start, 1, p_trow, p_tcol);
            else add_tok(K_ERROR, E_DOUBLE, p_start, 0, p_trow, p_tcol);
            rescan = 1'b1;
          end
        end
      end
      M_COMMENT: begin
        if (ch == 0) rescan = 1'b1;
        else if (ch == 8'h0a) p_mode = M_IDLE;
      end
      default: rescan = 1'b1;
    endcase
    if (rescan) scan_idle(ch, o, r, c);
    if (p_end) lex_reset();
    else begin
      p_row = r; p_col = c; p_off = inc24(p_off);
    end
    if (p_new.size() > 0) p_new[p_new.size()-1].last = 1'b1;
    foreach (p_new[i]) tok_q.push_back(p_new[i]);
  endtask

  task automatic send_byte(logic [7:0] ch);
    int n;
    n = $urandom_range(0, 5);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_byte(ch);
    n_sent++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_char();
    string pool = "abcdefghijklmnopqrstuvwxyzABCZ_09.+-*/<>=!&|:()[]{},\"\\# \n\t";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      default: return pool[$urandom_range(0, pool.len()-1)];
    endcase
  endfunction

  task automatic send_phrase();
    string kws[12] = '{"if", "then", "else", "match", "with", "end", "true",
                       "false", "inf", "rename", "module", "endmod"};
    string ops[16] = '{"+=", "-=", "*=", "/=", "<=", ">=", "==", "!=", "&&",
                       "||", "::", "=>", "&=", "|=", ":=", "&"};
    int n;
    case ($urandom_range(0, 7))
      0: send_str(kws[$urandom_range(0, 11)]);
      1: send_str(ops[$urandom_range(0, 15)]);
      2: begin
        n = $urandom_range(1, 9);
        repeat (n) send_byte(8'($urandom_range(97, 122)));
      end
      3: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(48, 57)));
      4: begin
        send_byte(8'h22);
        repeat ($urandom_range(0, 6)) send_byte(($urandom_range(0, 4) == 0) ? "\\" : "x");
        if ($urandom_range(0, 5) != 0) send_byte(8'h22);
      end
      5: begin
        send_byte("#");
        repeat ($urandom_range(0, 4)) send_byte("c");
        send_byte(8'h0a);
      end
      default: send_byte(rand_char());
    endcase
    if ($urandom_range(0, 2) == 0) send_byte(" ");
  endtask

  // stimulus
  initial begin
    stim_t tbl[$];
    stim_t rw;
    lex_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: byte, optional hand-typed kind/error of its first token
    tbl = '{
      '{8'h00, 1'b1, K_END, E_NONE},    '{8'hFF, 1'b1, K_ERROR, E_SYMBOL},
      '{8'h80, 1'b1, K_ERROR, E_SYMBOL}, '{"(", 1'b1, K_LPAREN, E_NONE},
      '{"_", 1'b0, 0, 0},               '{" ", 1'b1, K_CATCH, E_NONE},
      '{"&", 1'b0, 0, 0},               '{"=", 1'b1, K_ERROR, E_DOUBLE},
      '{"|", 1'b0, 0, 0},               '{"x", 1'b1, K_ERROR, E_DOUBLE},
      '{"9", 1'b0, 0, 0},               '{")", 1'b1, K_IDENT, E_NONE},
      '{"=", 1'b0, 0, 0},               '{">", 1'b1, K_ARROW, E_NONE},
      '{8'h22, 1'b0, 0, 0},             '{"\\", 1'b0, 0, 0},
      '{8'h00, 1'b1, K_END, E_NONE},    '{"#", 1'b0, 0, 0},
      '{8'h00, 1'b1, K_END, E_NONE},    '{"Z", 1'b0, 0, 0},
      '{8'h00, 1'b1, K_IDENT, E_NONE},  '{":", 1'b0, 0, 0},
      '{8'h0a, 1'b1, K_COLON, E_NONE},  '{8'h07, 1'b1, K_ERROR, E_SYMBOL}
    };
    foreach (tbl[i]) begin
      rw = tbl[i];
      send_byte(rw.ch);
      if (rw.has_tok && (p_new.size() == 0 || p_new[0].kind != rw.kind ||
                         p_new[0].err != rw.err)) begin
        $display("%0t table row %0d: expected kind %0d err %0d, model gave %0d",
                 $time, i, rw.kind, rw.err, p_new.size() ? p_new[0].kind : 6'h3f);
        n_err++;
      end
    end
    send_str("if then else match with end true false inf rename module endmod ");
    send_str("\"a\\\"b\" [1]{2},3 abcdefghij a.b ");
    send_byte(8'h00);
    hold_on = 1'b1;
    while (n_sent < 545) begin
      send_phrase();
      if ($urandom_range(0, 40) == 0) send_byte(8'h00);
    end
    send_byte(8'h00);
    in_tvalid <= 1'b0;
    src_done = 1'b1;
  end

  // receiver: random idling, one long hold-off
  initial begin
    int hold;
    int n;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_on) begin
        hold_on = 1'b0;
        out_tready <= 1'b0;
        for (hold = 0; hold < 200; hold++) @(posedge clk);
      end
      n = $urandom_range(0, 5);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // checker and watchdog
  always @(posedge clk) begin
    tok_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (tok_q.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual kind %0d data %h",
                 $time, out_tuser, out_tdata);
        n_err++;
      end else begin
        e = tok_q.pop_front();
        if (out_tuser != e.kind ||
            out_tdata != {14'd0, e.col, e.row, e.len, e.start, e.err} ||
            out_tlast != e.last) begin
          $display("%0t mismatch: expected kind %0d data %h last %b, actual %0d %h %b",
                   $time, e.kind, {14'd0, e.col, e.row, e.len, e.start, e.err}, e.last,
                   out_tuser, out_tdata, out_tlast);
          n_err++;
        end
      end
    end
  end

  initial begin
    int quiet;
    int tail;
    quiet = 0;
    tail = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
      if (src_done && tok_q.size() == 0) tail++;
      if (tail >= 20) begin
        if (n_err == 0) $display("tb_top: clean");
        else $display("tb_top: errors");
        $finish;
      end
    end
  end

endmodule
